>>> rtl/core/iff_pkg.sv
// Shared types and constants for the integer field formatter.
// Holds the controller state encoding, the command and status words
// between controller and datapath, and the ASCII codes used in the field.
package iff_pkg;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_NORM  = 5'b00100,
        ST_SETUP = 5'b01000,
        ST_EMIT  = 5'b10000
    } iff_state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic norm_step;
        logic setup;
        logic emit;
    } iff_cmd_t;

    typedef struct packed {
        logic hex;
        logic conv_last;
        logic norm_done;
        logic emit_last;
    } iff_status_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A_LC  = 8'h61;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

endpackage

>>> rtl/core/integer_field_formatter.sv
// Integer field formatter, printf style: %d or %x with width and precision.
// Top level; joins iff_ctrl and iff_datapath, uses iff_pkg.
//
// Each accepted word is one value to format; the block returns the field
// one character per output word, leading spaces, a minus for a negative
// decimal value, precision zeros, then the digits, with last set on the
// final character. An empty conversion gives a single word with char_valid
// low and last high. A decimal value is loaded, converted by the
// shift-add-3 BCD converter, stripped of leading zero digits down to at
// least one (NDIG = 10 digits at 32 bits) and set up; then one character
// is emitted per cycle while the output is not stalled. A hex value skips
// the converter. The next value is taken once the last character has
// entered the output register.
module integer_field_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            field_width,
    input  logic [5:0]            digit_precision,
    input  logic                  precision_given,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  char_valid,
    output logic                  last
);
    import iff_pkg::*;

    iff_cmd_t    cmd;
    iff_status_t status;

    iff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    iff_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (mode),
        .value           (value),
        .field_width     (field_width),
        .digit_precision (digit_precision),
        .precision_given (precision_given),
        .out_char        (out_char),
        .char_valid      (char_valid),
        .last            (last)
    );

endmodule

>>> rtl/core/iff_ctrl.sv
// Sequencer of the integer field formatter.
// Steps through load, conversion, digit normalization, setup and emission;
// depends on iff_pkg for the state and the command and status words.
module iff_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  iff_pkg::iff_status_t status,
    output iff_pkg::iff_cmd_t    cmd
);
    import iff_pkg::*;

    iff_state_t state_reg;
    iff_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    // output register is free when empty or being taken this cycle
    assign emit = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit      = emit;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = !status.hex;
                if (status.hex || status.conv_last)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit && status.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/iff_datapath.sv
// Datapath of the integer field formatter: magnitude, shift-add-3
// binary to BCD converter, digit normalizer, field counters and the
// output word register. Depends on iff_pkg; driven by iff_ctrl.
module iff_datapath #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 63
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  iff_pkg::iff_cmd_t       cmd,
    output iff_pkg::iff_status_t    status,
    input  logic                    mode,
    input  logic [VALUE_BITS-1:0]   value,
    input  logic [5:0]              field_width,
    input  logic [5:0]              digit_precision,
    input  logic                    precision_given,
    output logic [7:0]              out_char,
    output logic                    char_valid,
    output logic                    last
);
    import iff_pkg::*;

    localparam int DEC_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DW   = NDIG * 4;
    localparam int DCW  = $clog2(NDIG + 1);
    localparam int BCW  = $clog2(VALUE_BITS + 1);
    localparam int CW   = $clog2(MAX_FIELD + NDIG + 2);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [DW-1:0]         dig_reg, dig_next;
    logic [BCW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]        dig_cnt_reg, dig_cnt_next;
    logic                  neg_reg, neg_next;
    logic                  hex_reg, hex_next;
    logic                  suppress_reg, suppress_next;
    logic                  sign_reg, sign_next;
    logic                  empty_reg, empty_next;
    logic [CW-1:0]         prec_reg, prec_next;
    logic [CW-1:0]         width_reg, width_next;
    logic [CW-1:0]         spaces_reg, spaces_next;
    logic [CW-1:0]         zeros_reg, zeros_next;
    logic [CW-1:0]         remain_reg, remain_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  char_valid_reg, char_valid_next;
    logic                  last_reg, last_next;

    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [CW-1:0]         in_prec;
    logic [CW-1:0]         in_width;
    logic [DW-1:0]         dig_adj;
    logic [3:0]            top_digit;
    logic [7:0]            digit_char;
    logic [CW-1:0]         nd;
    logic [CW-1:0]         zeros_calc;
    logic [CW-1:0]         putlen;
    logic [CW-1:0]         total;
    logic                  word_last;

    assign in_neg    = !mode && value[VALUE_BITS-1];
    assign in_mag    = in_neg ? (~value + 1'b1) : value;
    assign in_prec   = precision_given ? CW'(digit_precision) : '0;
    assign in_width  = CW'(field_width);
    assign top_digit = dig_reg[DW-1 -: 4];
    assign digit_char = (top_digit >= 4'd10) ? (CHAR_A_LC + 8'(top_digit) - 8'd10)
                                             : (CHAR_ZERO + 8'(top_digit));
    assign word_last = empty_reg || (remain_reg == CW'(1));

    // add 3 to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            dig_adj[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ? (dig_reg[i*4 +: 4] + 4'd3)
                                                            : dig_reg[i*4 +: 4];
        end
    end

    // field layout from the digit count
    always_comb
    begin
        nd         = suppress_reg ? '0 : CW'(dig_cnt_reg);
        zeros_calc = (prec_reg > nd) ? (prec_reg - nd) : '0;
        putlen     = CW'(neg_reg) + zeros_calc + nd;
        total      = (width_reg > putlen) ? width_reg : putlen;
    end

    always_comb
    begin
        mag_next         = mag_reg;
        dig_next         = dig_reg;
        bit_cnt_next     = bit_cnt_reg;
        dig_cnt_next     = dig_cnt_reg;
        neg_next         = neg_reg;
        hex_next         = hex_reg;
        suppress_next    = suppress_reg;
        sign_next        = sign_reg;
        empty_next       = empty_reg;
        prec_next        = prec_reg;
        width_next       = width_reg;
        spaces_next      = spaces_reg;
        zeros_next       = zeros_reg;
        remain_next      = remain_reg;
        out_char_next    = out_char_reg;
        char_valid_next  = char_valid_reg;
        last_next        = last_reg;

        if (cmd.load)
        begin
            neg_next      = in_neg;
            hex_next      = mode;
            mag_next      = in_mag;
            dig_next      = mode ? DW'(value) : '0;
            bit_cnt_next  = BCW'(VALUE_BITS);
            dig_cnt_next  = DCW'(NDIG);
            suppress_next = precision_given && (digit_precision == '0) && (value == '0);
            prec_next     = (in_prec > CW'(MAX_FIELD - 1)) ? CW'(MAX_FIELD - 1) : in_prec;
            width_next    = (in_width > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : in_width;
        end

        if (cmd.conv_step)
        begin
            dig_next     = {dig_adj[DW-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end

        // drop leading zero digits, keep at least one
        if (cmd.norm_step)
        begin
            dig_next     = {dig_reg[DW-5:0], 4'b0000};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end

        if (cmd.setup)
        begin
            zeros_next       = zeros_calc;
            spaces_next      = total - putlen;
            remain_next      = (total > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : total;
            empty_next       = (total == '0);
            sign_next        = neg_reg;
        end

        if (cmd.emit)
        begin
            last_next = word_last;
            if (empty_reg)
            begin
                out_char_next   = CHAR_NONE;
                char_valid_next = 1'b0;
            end
            else
            begin
                char_valid_next = 1'b1;
                remain_next     = remain_reg - 1'b1;
                priority if (spaces_reg != '0)
                begin
                    out_char_next = CHAR_SPACE;
                    spaces_next   = spaces_reg - 1'b1;
                end
                else if (sign_reg)
                begin
                    out_char_next = CHAR_MINUS;
                    sign_next     = 1'b0;
                end
                else if (zeros_reg != '0)
                begin
                    out_char_next = CHAR_ZERO;
                    zeros_next    = zeros_reg - 1'b1;
                end
                else
                begin
                    out_char_next    = digit_char;
                    dig_next         = {dig_reg[DW-5:0], 4'b0000};
                end
            end
        end
    end

    always_comb
    begin
        status.hex       = hex_reg;
        status.conv_last = (bit_cnt_reg == BCW'(1));
        status.norm_done = (dig_cnt_reg == DCW'(1)) || (top_digit != 4'd0);
        status.emit_last = word_last;
    end

    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg         <= '0;
            dig_reg         <= '0;
            bit_cnt_reg     <= '0;
            dig_cnt_reg     <= '0;
            neg_reg         <= 1'b0;
            hex_reg         <= 1'b0;
            suppress_reg    <= 1'b0;
            sign_reg        <= 1'b0;
            empty_reg       <= 1'b0;
            prec_reg        <= '0;
            width_reg       <= '0;
            spaces_reg      <= '0;
            zeros_reg       <= '0;
            remain_reg      <= '0;
            out_char_reg    <= '0;
            char_valid_reg  <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            mag_reg         <= mag_next;
            dig_reg         <= dig_next;
            bit_cnt_reg     <= bit_cnt_next;
            dig_cnt_reg     <= dig_cnt_next;
            neg_reg         <= neg_next;
            hex_reg         <= hex_next;
            suppress_reg    <= suppress_next;
            sign_reg        <= sign_next;
            empty_reg       <= empty_next;
            prec_reg        <= prec_next;
            width_reg       <= width_next;
            spaces_reg      <= spaces_next;
            zeros_reg       <= zeros_next;
            remain_reg      <= remain_next;
            out_char_reg    <= out_char_next;
            char_valid_reg  <= char_valid_next;
            last_reg        <= last_next;
        end
    end

endmodule
